>>> rtl/pol_pkg.sv
// Shared types and constants for the positional ordered list unit.
// Has no dependencies. Imported by the top level.
`default_nettype none

package pol_pkg;

    localparam int POL_CAPACITY = 64;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 7;
    localparam int ACT_W        = 3;
    localparam int FOUND_W      = 6;
    localparam int CNT_OUT_W    = 7;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_SEARCH = 3'd2,
        ACT_GET    = 3'd3,
        ACT_CLEAR  = 3'd4
    } t_action;

endpackage

`default_nettype wire

>>> rtl/pol_ram.sv
// Generic simple dual-port RAM: one write port and one registered read port.
// Stand-alone, with no package dependency.
`default_nettype none

module pol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read returns the old contents on a same-address collision.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> rtl/positional_ordered_list_unit.sv
// Positional ordered list unit: top level with the sequencer and result register.
// Depends on pol_pkg and pol_ram.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit values in one
// synchronous RAM plus an entry count, and runs one transaction at a time:
// insert at a position (later entries move back), remove at a position (the
// gap closes), search for the first equal value, get the value at a position,
// or clear. Every transaction gives exactly one result carrying status,
// found index, read value and the entry count after the action. All work goes
// through the single read port and single write port of the element RAM, one
// entry per cycle, so the time a transaction takes (from acceptance to the
// result being presented) depends on the list contents and the position.
// A new transaction is taken once the previous one has reached the result
// register, even if that result is still waiting to be taken downstream.
// The element RAM needs no clearing pass: only entries below the count are
// ever read and those have always been written.
`default_nettype none

module positional_ordered_list_unit import pol_pkg::*; #(
    parameter int CAPACITY = POL_CAPACITY
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // Request channel
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [ACT_W-1:0]         i_action,
    input  wire logic [POS_W-1:0]         i_position,
    input  wire logic signed [DATA_W-1:0] i_value,
    // Result channel
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic                          o_status,
    output logic [FOUND_W-1:0]            o_found_index,
    output logic signed [DATA_W-1:0]      o_read_value,
    output logic [CNT_OUT_W-1:0]          o_entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_INS      = 7'b0000010,
        S_INS_FILL = 7'b0000100,
        S_REM      = 7'b0001000,
        S_SRCH     = 7'b0010000,
        S_GET      = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_ptr,   n_ptr;
    logic [AW-1:0]       r_pos,   n_pos;
    logic [DATA_W-1:0]   r_val,   n_val;
    logic                r_res_status, n_res_status;
    logic [FOUND_W-1:0]  r_res_found,  n_res_found;
    logic [DATA_W-1:0]   r_res_read,   n_res_read;

    logic                r_o_valid;
    logic                r_o_status;
    logic [FOUND_W-1:0]  r_o_found;
    logic [DATA_W-1:0]   r_o_read;
    logic [CNT_OUT_W-1:0] r_o_count;

    logic                in_acc;
    logic                out_free;
    logic [PW-1:0]       pos_ext;
    logic [PW-1:0]       cnt_ext;
    logic [AW-1:0]       pos_a;
    logic [AW-1:0]       cnt_a;

    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [DATA_W-1:0]   ram_wr_data;
    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;
    logic [DATA_W-1:0]   ram_rd_data;

    // Take a new transaction only when the sequencer is idle.
    assign o_ready  = (r_state == S_IDLE);
    assign in_acc   = i_valid & o_ready;
    // The result register can be loaded when empty or when being drained.
    assign out_free = !r_o_valid || i_ready;

    // Range checks run at the wider of the position and count widths.
    assign pos_ext = PW'(i_position);
    assign cnt_ext = PW'(r_count);
    assign pos_a   = AW'(i_position);
    assign cnt_a   = AW'(r_count);

    pol_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_elem_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_pos        = r_pos;
        n_val        = r_val;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_res_read   = r_res_read;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_ptr;
        ram_wr_data  = ram_rd_data;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_val        = i_value;
                    n_pos        = pos_a;
                    n_res_status = 1'b1;
                    n_res_found  = '0;
                    n_res_read   = '0;
                    n_state      = S_DONE;
                    unique case (i_action)
                        ACT_INSERT: begin
                            if (pos_ext <= cnt_ext && r_count < CAP_C) begin
                                n_res_status = 1'b0;
                                if (pos_ext == cnt_ext) begin
                                    // Append: no entries to move.
                                    ram_wr_en   = 1'b1;
                                    ram_wr_addr = pos_a;
                                    ram_wr_data = i_value;
                                    n_count     = r_count + CW'(1);
                                end else begin
                                    // Start moving entries back from the tail.
                                    ram_rd_en   = 1'b1;
                                    ram_rd_addr = cnt_a - AW'(1);
                                    n_ptr       = cnt_a;
                                    n_state     = S_INS;
                                end
                            end
                        end
                        ACT_REMOVE: begin
                            if (pos_ext < cnt_ext) begin
                                n_res_status = 1'b0;
                                if (pos_ext + PW'(1) == cnt_ext) begin
                                    n_count = r_count - CW'(1);
                                end else begin
                                    ram_rd_en   = 1'b1;
                                    ram_rd_addr = pos_a + AW'(1);
                                    n_ptr       = pos_a;
                                    n_state     = S_REM;
                                end
                            end
                        end
                        ACT_SEARCH: begin
                            if (r_count != '0) begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = '0;
                                n_ptr       = '0;
                                n_state     = S_SRCH;
                            end
                        end
                        ACT_GET: begin
                            if (pos_ext < cnt_ext) begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = pos_a;
                                n_state     = S_GET;
                            end
                        end
                        ACT_CLEAR: begin
                            n_count      = '0;
                            n_res_status = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_INS: begin
                // Write entry ptr-1 into slot ptr; read the next one down.
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_ptr;
                ram_wr_data = ram_rd_data;
                if (r_ptr - AW'(1) == r_pos) begin
                    n_state = S_INS_FILL;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_ptr - AW'(2);
                    n_ptr       = r_ptr - AW'(1);
                end
            end
            S_INS_FILL: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_pos;
                ram_wr_data = r_val;
                n_count     = r_count + CW'(1);
                n_state     = S_DONE;
            end
            S_REM: begin
                // Write entry ptr+1 into slot ptr; read the next one up.
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_ptr;
                ram_wr_data = ram_rd_data;
                if (CW'(r_ptr) + CW'(2) == r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_ptr + AW'(2);
                    n_ptr       = r_ptr + AW'(1);
                end
            end
            S_SRCH: begin
                if (ram_rd_data == r_val) begin
                    n_res_status = 1'b0;
                    n_res_found  = FOUND_W'(r_ptr);
                    n_state      = S_DONE;
                end else if (CW'(r_ptr) + CW'(1) == r_count) begin
                    n_state = S_DONE;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_ptr + AW'(1);
                    n_ptr       = r_ptr + AW'(1);
                end
            end
            S_GET: begin
                n_res_status = 1'b0;
                n_res_read   = ram_rd_data;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Working registers and result payload: no reset needed.
    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_pos        <= n_pos;
        r_val        <= n_val;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_res_read   <= n_res_read;
        if (r_state == S_DONE && out_free) begin
            r_o_status <= r_res_status;
            r_o_found  <= r_res_found;
            r_o_read   <= r_res_read;
            r_o_count  <= CNT_OUT_W'(r_count);
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_found_index = r_o_found;
    assign o_read_value  = r_o_read;
    assign o_entry_count = r_o_count;

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    // Shifting for an insert only runs on a list that is not full.
    a_ins_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS || r_state == S_INS_FILL) |-> r_count < CAP_C)
        else $error("insert shift on a full list");

    // A scan never starts on an empty list.
    a_srch_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SRCH |-> r_count != '0)
        else $error("search scan on empty list");

    // A clear empties the list in the following cycle.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_action == ACT_CLEAR) |=> r_count == '0)
        else $error("clear did not empty the list");

    // The RAM is written only while a transaction is under way.
    a_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr_en |-> (r_state != S_IDLE || in_acc))
        else $error("element RAM written while idle");

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the positional ordered list unit: directed and random
// list transactions, checked against a behavioural shadow of the list.
// Depends on pol_pkg and positional_ordered_list_unit.

module tb_top;
    import pol_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int MAX_POSITION   = 2**POS_W - 1;
    localparam int NUM_ACTIONS    = int'(ACT_CLEAR) + 1;
    localparam int HOLD_CYCLES    = 250;
    localparam int FIRST_HOLD_AT  = 350;
    localparam int SECOND_HOLD_AT = 900;
    // Slowest transactions: an insert at the head of a 63-entry list, a search miss on a full list.
    localparam int SETTLE_CYCLES  = 100;
    localparam longint TIMEOUT_NS = 10_000_000;

    localparam logic [ACT_W-1:0] ACT_FIRST_UNKNOWN = ACT_W'(int'(ACT_CLEAR) + 1);
    localparam logic [ACT_W-1:0] ACT_LAST_CODE     = '1;

    localparam logic [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MOST_POSITIVE = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
        logic              drain_first;   // wait for every result before offering this one
    } list_request_t;

    typedef struct packed {
        logic               status;
        logic [FOUND_W-1:0] found_index;
        logic [DATA_W-1:0]  read_value;
        logic [CNT_OUT_W-1:0] entry_count;
    } list_reply_t;

    typedef enum int {RX_STEADY, RX_COIN, RX_RUNS} rx_mode_t;

    // ------------------------------------------------------------------
    // Block interface
    // ------------------------------------------------------------------
    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_valid    = 1'b0;
    logic                     o_ready;
    logic [ACT_W-1:0]         i_action   = '0;
    logic [POS_W-1:0]         i_position = '0;
    logic signed [DATA_W-1:0] i_value    = '0;
    logic                     o_valid;
    logic                     i_ready    = 1'b0;
    logic                     o_status;
    logic [FOUND_W-1:0]       o_found_index;
    logic signed [DATA_W-1:0] o_read_value;
    logic [CNT_OUT_W-1:0]     o_entry_count;

    positional_ordered_list_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_found_index(o_found_index),
        .o_read_value (o_read_value),
        .o_entry_count(o_entry_count)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow of the list, advanced once per accepted request transaction
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] shadow_list [POL_CAPACITY];
    int                shadow_count = 0;

    list_request_t pending_reqs[$];      // stimulus not yet offered
    list_reply_t   expected_replies[$];  // results owed by the block, oldest first

    // Entry count as the stimulus generator sees it, used to aim positions.
    int gen_count = 0;

    logic req_taken = 1'b0;  // request transaction accepted at the last rising edge
    int   accepted_reqs   = 0;
    int   replies_checked = 0;
    int   error_count     = 0;
    int   rejected_count  = 0;
    int   full_rejects    = 0;
    int   unknown_seen    = 0;
    int   peak_count      = 0;
    int   action_seen [NUM_ACTIONS] = '{default: 0};

    // Sender burst state and receiver stall state
    int       burst_left   = 0;
    int       gap_left     = 0;
    int       hold_left    = 0;
    int       holds_done   = 0;
    rx_mode_t rx_mode      = RX_STEADY;
    int       rx_mode_left = 0;
    int       run_left     = 0;
    bit       run_ready    = 1'b0;

    // Work out the result of one list action and update the shadow accordingly.
    function automatic list_reply_t apply_list_action(input logic [ACT_W-1:0] act,
                                                      input logic [POS_W-1:0] pos,
                                                      input logic [DATA_W-1:0] val);
        list_reply_t rep;
        int          p;
        int          k;
        bit          hit;
        rep.status      = 1'b1;
        rep.found_index = '0;
        rep.read_value  = '0;
        p   = int'(pos);
        hit = 1'b0;
        case (act)
            ACT_INSERT: begin
                if (p <= shadow_count && shadow_count < POL_CAPACITY) begin
                    for (k = shadow_count; k > p; k--)
                        shadow_list[k] = shadow_list[k-1];
                    shadow_list[p] = val;
                    shadow_count++;
                    rep.status = 1'b0;
                end
            end
            ACT_REMOVE: begin
                if (p < shadow_count) begin
                    for (k = p; k + 1 < shadow_count; k++)
                        shadow_list[k] = shadow_list[k+1];
                    shadow_count--;
                    rep.status = 1'b0;
                end
            end
            ACT_SEARCH: begin
                for (k = 0; k < shadow_count; k++) begin
                    if (!hit && shadow_list[k] == val) begin
                        hit             = 1'b1;
                        rep.found_index = FOUND_W'(k);
                        rep.status      = 1'b0;
                    end
                end
            end
            ACT_GET: begin
                if (p < shadow_count) begin
                    rep.read_value = shadow_list[p];
                    rep.status     = 1'b0;
                end
            end
            ACT_CLEAR: begin
                shadow_count = 0;
                rep.status   = 1'b0;
            end
            default: ;  // unknown codes are rejected and change nothing
        endcase
        rep.entry_count = CNT_OUT_W'(shadow_count);
        return rep;
    endfunction

    task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("t=%0d ns: %s mismatch on result %0d, expected 0x%h, actual 0x%h",
                     $time, field, replies_checked, want, got);
            error_count++;
        end
    endtask

    // Queue one request and keep the generator's idea of the count in step.
    task automatic push_req(input logic [ACT_W-1:0] act, input int pos,
                            input logic [DATA_W-1:0] val, input bit drain);
        list_request_t r;
        r.action      = act;
        r.position    = POS_W'(pos);
        r.value       = val;
        r.drain_first = drain;
        pending_reqs.push_back(r);
        case (act)
            ACT_INSERT: if (pos <= gen_count && gen_count < POL_CAPACITY) gen_count++;
            ACT_REMOVE: if (pos < gen_count) gen_count--;
            ACT_CLEAR:  gen_count = 0;
            default: ;
        endcase
    endtask

    // Mostly a small pool, so that searches hit and duplicates appear; else anything.
    function automatic logic [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)      return MOST_NEGATIVE;
        else if (sel == 1) return MOST_POSITIVE;
        else if (sel == 2) return '1;
        else if (sel == 3) return '0;
        else if (sel < 10) return DATA_W'($urandom_range(1, 6));
        else               return $urandom();
    endfunction

    // One request of any kind, positions mostly in range for the current count.
    task automatic push_mixed(input bit drain);
        int  sel;
        int  any_pos;
        int  held_pos;
        bit  wild;
        sel     = $urandom_range(0, 99);
        any_pos = $urandom_range(0, MAX_POSITION);
        wild    = ($urandom_range(0, 9) == 0);
        if (gen_count == 0 || wild) held_pos = any_pos;
        else                        held_pos = $urandom_range(0, gen_count - 1);
        if (sel < 30)
            push_req(ACT_INSERT, wild ? any_pos : $urandom_range(0, gen_count),
                     pick_value(), drain);
        else if (sel < 50)
            push_req(ACT_REMOVE, held_pos, $urandom(), drain);
        else if (sel < 70)
            push_req(ACT_SEARCH, any_pos, pick_value(), drain);
        else if (sel < 93)
            push_req(ACT_GET, held_pos, $urandom(), drain);
        else if (sel < 96)
            push_req(ACT_CLEAR, any_pos, $urandom(), drain);
        else
            push_req(ACT_W'($urandom_range(ACT_FIRST_UNKNOWN, ACT_LAST_CODE)), any_pos,
                     $urandom(), drain);
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge. Check the result
    // transaction first, since it always belongs to an earlier request.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        list_reply_t want;
        req_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_replies.size() == 0) begin
                $display("t=%0d ns: result with none outstanding, actual status %b index %0d",
                         $time, o_status, o_found_index);
                $display("    value 0x%h count %0d", o_read_value, o_entry_count);
                error_count++;
            end else begin
                want = expected_replies.pop_front();
                check_field("status", want.status, o_status);
                check_field("found_index", want.found_index, o_found_index);
                check_field("read_value", want.read_value, o_read_value);
                check_field("entry_count", want.entry_count, o_entry_count);
            end
            replies_checked++;
        end
        if (i_rst_n && i_valid && o_ready) begin
            if (i_action == ACT_INSERT && shadow_count == POL_CAPACITY) full_rejects++;
            want = apply_list_action(i_action, i_position, i_value);
            expected_replies.push_back(want);
            if (want.status) rejected_count++;
            if (i_action <= ACT_CLEAR) action_seen[i_action]++;
            else                       unknown_seen++;
            if (shadow_count > peak_count) peak_count = shadow_count;
            accepted_reqs++;
        end
    end

    // ------------------------------------------------------------------
    // Driver: change inputs at the falling edge only. Hold valid and the
    // payload until the transaction goes through, then either offer the
    // next request or drop valid for a gap between bursts.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        list_request_t nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_taken) begin
            if (pending_reqs.size() == 0 ||
                (pending_reqs[0].drain_first && expected_replies.size() != 0)) begin
                i_valid <= 1'b0;
            end else if (burst_left == 0 && gap_left != 0 && hold_left == 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else begin
                // Start a fresh burst; about a quarter of them run on with no gap.
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                burst_left--;
                nxt = pending_reqs.pop_front();
                i_valid    <= 1'b1;
                i_action   <= nxt.action;
                i_position <= nxt.position;
                i_value    <= nxt.value;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: switch between always ready, coin-toss ready and runs of
    // stalls. Twice in the run, hold off for a long stretch so that the
    // result register fills and the block stops taking requests.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if ((holds_done == 0 && accepted_reqs >= FIRST_HOLD_AT) ||
                     (holds_done == 1 && accepted_reqs >= SECOND_HOLD_AT)) begin
            holds_done++;
            hold_left <= HOLD_CYCLES - 1;
            i_ready   <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = rx_mode_t'($urandom_range(0, int'(RX_RUNS)));
                rx_mode_left = $urandom_range(64, 256);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_STEADY: i_ready <= 1'b1;
                RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
                default: begin
                    if (run_left == 0) begin
                        run_ready = !run_ready;
                        run_left  = run_ready ? $urandom_range(1, 8) : $urandom_range(1, 12);
                    end
                    run_left--;
                    i_ready <= run_ready;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        int total_items;
        int phase;
        int target;
        int pos;
        bit drain;
        bit first_phase;
        int code;

        // Directed: empty-list rejections, extremes, first-match search,
        // ends of the list, out-of-range positions and unknown codes.
        push_req(ACT_CLEAR, 0, '0, 1'b0);
        push_req(ACT_GET, 0, '0, 1'b0);
        push_req(ACT_REMOVE, 0, '0, 1'b0);
        push_req(ACT_SEARCH, 0, '0, 1'b0);
        push_req(ACT_INSERT, 1, 32'd5, 1'b0);                // past the end
        push_req(ACT_INSERT, 0, MOST_NEGATIVE, 1'b0);
        push_req(ACT_INSERT, 1, MOST_POSITIVE, 1'b0);
        push_req(ACT_INSERT, 0, '1, 1'b0);                   // at the head
        push_req(ACT_INSERT, 3, MOST_POSITIVE, 1'b0);        // append a duplicate
        push_req(ACT_INSERT, POL_CAPACITY, '0, 1'b0);
        push_req(ACT_INSERT, MAX_POSITION, '0, 1'b0);
        push_req(ACT_SEARCH, 0, MOST_POSITIVE, 1'b0);        // first of two matches
        push_req(ACT_SEARCH, MAX_POSITION, MOST_NEGATIVE, 1'b0);
        push_req(ACT_SEARCH, 0, 32'd12345, 1'b0);            // miss
        push_req(ACT_GET, 0, '1, 1'b0);
        push_req(ACT_GET, 3, '0, 1'b0);
        push_req(ACT_GET, 4, '0, 1'b0);                      // one past the end
        push_req(ACT_GET, MAX_POSITION, '0, 1'b0);
        push_req(ACT_REMOVE, 4, '0, 1'b0);
        push_req(ACT_REMOVE, 3, '0, 1'b0);                   // last entry
        push_req(ACT_REMOVE, 0, '0, 1'b0);                   // first entry
        for (code = ACT_FIRST_UNKNOWN; code <= ACT_LAST_CODE; code++)
            push_req(ACT_W'(code), 0, '1, 1'b0);
        push_req(ACT_CLEAR, MAX_POSITION, '1, 1'b0);
        push_req(ACT_GET, 0, '0, 1'b0);

        // Random: phases that grow the list (often to full), churn it,
        // shrink it to empty, or clear it and throw noise at it.
        total_items = pending_reqs.size() + RANDOM_ITEMS;
        first_phase = 1'b1;
        while (pending_reqs.size() < total_items) begin
            phase       = $urandom_range(0, 9);
            drain       = first_phase || ($urandom_range(0, 3) == 0);
            first_phase = 1'b0;
            if (phase < 4) begin
                target = ($urandom_range(0, 2) == 0) ? POL_CAPACITY
                                                      : $urandom_range(gen_count, POL_CAPACITY);
                while (gen_count < target) begin
                    if ($urandom_range(0, 3) == 0) begin
                        push_mixed(drain);
                    end else begin
                        case ($urandom_range(0, 3))
                            0:       pos = 0;
                            1:       pos = gen_count;
                            default: pos = $urandom_range(0, gen_count);
                        endcase
                        push_req(ACT_INSERT, pos, pick_value(), drain);
                    end
                    drain = 1'b0;
                end
                if (gen_count == POL_CAPACITY)
                    repeat ($urandom_range(1, 3))
                        push_req(ACT_INSERT, $urandom_range(0, POL_CAPACITY), pick_value(), 1'b0);
            end else if (phase < 7) begin
                repeat ($urandom_range(20, 60)) begin
                    push_mixed(drain);
                    drain = 1'b0;
                end
            end else if (phase < 9) begin
                while (gen_count > 0) begin
                    if ($urandom_range(0, 4) == 0) begin
                        push_mixed(drain);
                    end else begin
                        case ($urandom_range(0, 3))
                            0:       pos = 0;
                            1:       pos = gen_count - 1;
                            default: pos = $urandom_range(0, gen_count - 1);
                        endcase
                        push_req(ACT_REMOVE, pos, $urandom(), drain);
                    end
                    drain = 1'b0;
                end
                push_req(ACT_GET, $urandom_range(0, MAX_POSITION), $urandom(), 1'b0);
                push_req(ACT_REMOVE, $urandom_range(0, MAX_POSITION), $urandom(), 1'b0);
            end else begin
                push_req(ACT_CLEAR, $urandom_range(0, MAX_POSITION), $urandom(), drain);
                repeat ($urandom_range(5, 12)) push_mixed(1'b0);
            end
        end
        // The last phase may run past the target: wait for everything queued.
        total_items = pending_reqs.size();

        // Hold reset, then release it on a falling edge.
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to go in and every result to come out,
        // then allow a little longer so that any stray result is caught.
        while (accepted_reqs < total_items) @(posedge i_clk);
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d transactions: %0d insert, %0d remove, %0d search, %0d get, %0d clear,",
                 accepted_reqs, action_seen[ACT_INSERT], action_seen[ACT_REMOVE],
                 action_seen[ACT_SEARCH], action_seen[ACT_GET], action_seen[ACT_CLEAR]);
        $display("%0d unknown; %0d rejected (%0d into a full list), peak %0d entries, %0d errors.",
                 unknown_seen, rejected_count, full_rejects, peak_count, error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("t=%0d ns: timed out with %0d requests in, %0d results outstanding",
                 $time, accepted_reqs, expected_replies.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/pol_pkg.sv
rtl/pol_ram.sv
rtl/positional_ordered_list_unit.sv
test/tb_top.sv
